FILE: rtl/core/ucdn_pkg.sv
// Shared types and constants for the Unicode decimal number parser.
// Holds the script zero table, field widths and the result struct.
// No dependencies.
`default_nettype none

package ucdn_pkg;

  localparam int CP_W     = 21;
  localparam int DIGIT_W  = 4;
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 16;
  localparam int ZERO_COUNT = 68;
  localparam logic [DIGIT_W-1:0] RADIX = DIGIT_W'(10);

  localparam logic [CP_W-1:0] ZERO_TABLE [ZERO_COUNT] = '{
    21'h00030, 21'h00660, 21'h006F0, 21'h007C0, 21'h00966, 21'h009E6, 21'h00A66,
    21'h00AE6, 21'h00B66, 21'h00BE6, 21'h00C66, 21'h00CE6, 21'h00D66, 21'h00DE6,
    21'h00E50, 21'h00ED0, 21'h00F20, 21'h01040, 21'h01090, 21'h017E0, 21'h01810,
    21'h01946, 21'h019D0, 21'h01A80, 21'h01A90, 21'h01B50, 21'h01BB0, 21'h01C40,
    21'h01C50, 21'h0A620, 21'h0A8D0, 21'h0A900, 21'h0A9D0, 21'h0A9F0, 21'h0AA50,
    21'h0ABF0, 21'h0FF10, 21'h104A0, 21'h10D30, 21'h11066, 21'h110F0, 21'h11136,
    21'h111D0, 21'h112F0, 21'h11450, 21'h114D0, 21'h11650, 21'h116C0, 21'h11730,
    21'h118E0, 21'h11950, 21'h11C50, 21'h11D50, 21'h11DA0, 21'h11F50, 21'h16A60,
    21'h16AC0, 21'h16B50, 21'h1D7CE, 21'h1D7D8, 21'h1D7E2, 21'h1D7EC, 21'h1D7F6,
    21'h1E140, 21'h1E2F0, 21'h1E4F0, 21'h1E950, 21'h1FBF0
  };

  typedef struct packed {
    logic               is_digit;
    logic [DIGIT_W-1:0] value;
  } digit_info_t;

  typedef struct packed {
    logic               is_digit;
    logic [DIGIT_W-1:0] digit_value;
    logic [VALUE_W-1:0] number_value;
    logic [COUNT_W-1:0] digits_taken;
    logic               done_res;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/ucdn_if.sv
// Valid/ready channel interfaces for code points in and parse results out.
// Depends on ucdn_pkg for field widths.
`default_nettype none

interface ucdn_req_if
  import ucdn_pkg::*;
  ;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            start_number;
  logic            last_in_line;

  modport source (output valid, code_point, start_number, last_in_line, input ready);
  modport sink   (input valid, code_point, start_number, last_in_line, output ready);
endinterface

interface ucdn_rsp_if
  import ucdn_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               is_digit;
  logic [DIGIT_W-1:0] digit_value;
  logic [VALUE_W-1:0] number_value;
  logic [COUNT_W-1:0] digits_taken;
  logic               done_res;

  modport source (output valid, is_digit, digit_value, number_value, digits_taken,
                  done_res, input ready);
  modport sink   (input valid, is_digit, digit_value, number_value, digits_taken,
                  done_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/unicode_decimal_number_parser_core.sv
// Top level of the Unicode decimal number parser.
// Depends on ucdn_pkg, ucdn_if, ucdn_digit and ucdn_accum.
//
// Accepts one code point per cycle unless stalled, and returns one result per
// code point through an input register, then the zero table compare and the
// multiply-by-ten update in one stage, then the result register. Sustained rate
// is one item per clock unless stalled; the path through the table compare and
// the 64-bit add sets the clock. Result-side backpressure stalls both registers.
`default_nettype none

module unicode_decimal_number_parser_core
  import ucdn_pkg::*;
#(
  parameter int ZERO_TABLE_SIZE = 68
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ucdn_req_if.sink   req,
  ucdn_rsp_if.source rsp
);

  logic            s1_valid;
  logic [CP_W-1:0] s1_code_point;
  logic            s1_start;
  logic            s1_last;
  logic            out_valid;
  logic            advance;
  logic            load;
  digit_info_t     info;
  result_t         result;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;
  assign load      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_code_point <= req.code_point;
      s1_start      <= req.start_number;
      s1_last       <= req.last_in_line;
    end
  end

  ucdn_digit #(
    .TABLE_SIZE (ZERO_TABLE_SIZE)
  ) u_digit (
    .code_point (s1_code_point),
    .info       (info)
  );

  ucdn_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .start_number (s1_start),
    .last_in_line (s1_last),
    .info         (info),
    .result       (result)
  );

  assign rsp.valid        = out_valid;
  assign rsp.is_digit     = result.is_digit;
  assign rsp.digit_value  = result.digit_value;
  assign rsp.number_value = result.number_value;
  assign rsp.digits_taken = result.digits_taken;
  assign rsp.done_res     = result.done_res;

endmodule

`default_nettype wire

FILE: rtl/core/ucdn_digit.sv
// Digit classifier: compares a code point against the script zero table.
// Depends on ucdn_pkg.
`default_nettype none

module ucdn_digit
  import ucdn_pkg::*;
#(
  parameter int TABLE_SIZE = 68
) (
  input  wire logic [CP_W-1:0] code_point,
  output digit_info_t          info
);

  logic [CP_W-1:0] diff [ZERO_COUNT];

  // Table is ascending: the highest matching zero gives the smallest difference.
  always_comb begin
    info = '0;
    for (int i = 0; i < ZERO_COUNT; i++) begin
      diff[i] = code_point - ZERO_TABLE[i];
      if (i < TABLE_SIZE && code_point >= ZERO_TABLE[i] &&
          diff[i] < CP_W'(RADIX)) begin
        info.is_digit = 1'b1;
        info.value    = diff[i][DIGIT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ucdn_accum.sv
// Number accumulator: holds value, digit count and open flag, and the result register.
// Depends on ucdn_pkg.
`default_nettype none

module ucdn_accum
  import ucdn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic        start_number,
  input  wire logic        last_in_line,
  input  digit_info_t      info,
  output result_t          result
);

  logic [VALUE_W-1:0] accumulator, accumulator_next, acc_base;
  logic [COUNT_W-1:0] digit_counter, digit_counter_next, cnt_base;
  logic               active, active_next, act_base;
  logic               done;

  always_comb begin
    acc_base = start_number ? '0 : accumulator;
    cnt_base = start_number ? '0 : digit_counter;
    act_base = start_number | active;

    accumulator_next   = acc_base;
    digit_counter_next = cnt_base;
    active_next        = act_base;
    done               = 1'b0;

    if (act_base) begin
      if (info.is_digit) begin
        accumulator_next = (acc_base << 3) + (acc_base << 1) + VALUE_W'(info.value);
        if (cnt_base != '1) begin
          digit_counter_next = cnt_base + COUNT_W'(1);
        end
      end
      if (!info.is_digit || last_in_line) begin
        done        = 1'b1;
        active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      digit_counter <= '0;
      active        <= 1'b0;
    end else if (load) begin
      accumulator   <= accumulator_next;
      digit_counter <= digit_counter_next;
      active        <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.is_digit     <= info.is_digit;
      result.digit_value  <= info.value;
      result.number_value <= accumulator_next;
      result.digits_taken <= digit_counter_next;
      result.done_res     <= done;
    end
  end

endmodule

`default_nettype wire

FILE: verif/ucdn_checker.sv
// Result checker for the Unicode decimal number parser core.
// Watches both channels, predicts each parse result and compares it field by field.
// Depends on ucdn_pkg and the channel interfaces in ucdn_if.
module ucdn_result_checker
  import ucdn_pkg::*;
#(
  parameter int TABLE_SIZE = 68
) (
  input  logic clk,
  input  logic rst,
  ucdn_req_if  req,
  ucdn_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  logic [VALUE_W-1:0] number_acc;
  logic [COUNT_W-1:0] digit_count;
  logic               number_open;
  result_t            parse_results_q[$];
  int                 mismatches;

  function automatic digit_info_t classify_code_point(input logic [CP_W-1:0] cp);
    logic [31:0] best;
    logic [31:0] diff;
    digit_info_t info;
    int          i;
    best = '1;
    for (i = 0; i < ZERO_COUNT && i < TABLE_SIZE; i++) begin
      diff = 32'(cp) - 32'(ZERO_TABLE[i]);
      if (diff < best) begin
        best = diff;
      end
    end
    info.is_digit = (best < 32'd10);
    info.value    = info.is_digit ? best[DIGIT_W-1:0] : '0;
    return info;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    digit_info_t info;
    result_t     predicted;
    result_t     observed;
    if (rst) begin
      number_acc  = '0;
      digit_count = '0;
      number_open = 1'b0;
      parse_results_q.delete();
      mismatches  = 0;
    end else begin
      if (req.valid && req.ready) begin
        info = classify_code_point(req.code_point);
        if (req.start_number) begin
          number_acc  = '0;
          digit_count = '0;
          number_open = 1'b1;
        end
        predicted.done_res = 1'b0;
        if (number_open) begin
          if (info.is_digit) begin
            number_acc = number_acc * 64'd10 + VALUE_W'(info.value);
            if (digit_count != '1) begin
              digit_count = digit_count + 1'b1;
            end
          end
          if (!info.is_digit || req.last_in_line) begin
            predicted.done_res = 1'b1;
            number_open        = 1'b0;
          end
        end
        predicted.is_digit     = info.is_digit;
        predicted.digit_value  = info.value;
        predicted.number_value = number_acc;
        predicted.digits_taken = digit_count;
        parse_results_q.push_back(predicted);
      end
      if (rsp.valid && rsp.ready) begin
        if (parse_results_q.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatches++;
        end else begin
          predicted             = parse_results_q.pop_front();
          observed.is_digit     = rsp.is_digit;
          observed.digit_value  = rsp.digit_value;
          observed.number_value = rsp.number_value;
          observed.digits_taken = rsp.digits_taken;
          observed.done_res     = rsp.done_res;
          check_field("is_digit", 64'(predicted.is_digit), 64'(observed.is_digit));
          check_field("digit_value", 64'(predicted.digit_value), 64'(observed.digit_value));
          check_field("number_value", predicted.number_value, observed.number_value);
          check_field("digits_taken", 64'(predicted.digits_taken),
                      64'(observed.digits_taken));
          check_field("done_res", 64'(predicted.done_res), 64'(observed.done_res));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= parse_results_q.size();
  end

endmodule

FILE: verif/unicode_decimal_number_parser_core_tb.sv
// Testbench top for the Unicode decimal number parser core.
// Drives code point transactions with random idling and back-pressure, gives the verdict.
// Depends on ucdn_pkg, ucdn_if, the core and ucdn_result_checker.
module unicode_decimal_number_parser_core_tb;
  import ucdn_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int LONG_HOLD    = 400;
  localparam int FLOOD_ITEMS  = 64;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   numbers_opened;
  int   idle_cycles;
  bit   quiet;
  bit   hold_pending;

  ucdn_req_if req_ch ();
  ucdn_rsp_if rsp_ch ();

  unicode_decimal_number_parser_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ucdn_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CP_W-1:0] random_digit();
    return ZERO_TABLE[$urandom_range(0, ZERO_COUNT - 1)] + CP_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [CP_W-1:0] random_separator();
    if ($urandom_range(0, 1) == 0) return CP_W'(21'h20 + $urandom_range(0, 15));
    return CP_W'($urandom_range(0, 21'h10FFFF));
  endfunction

  task automatic send_cp(input logic [CP_W-1:0] cp, input logic start, input logic last);
    int gap;
    gap = quiet ? 0 : idle_length();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.code_point   <= cp;
    req_ch.start_number <= start;
    req_ch.last_in_line <= last;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    if (start) numbers_opened++;
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_directed();
    send_cp(CP_W'(21'h00035), 1'b0, 1'b0);
    send_cp(CP_W'(21'h00041), 1'b0, 1'b0);
    send_cp(CP_W'(21'h00020), 1'b1, 1'b0);
    send_cp(CP_W'(21'h00039), 1'b1, 1'b0);
    send_cp(CP_W'(21'h1D7FF), 1'b0, 1'b0);
    send_cp(CP_W'(21'h1FBF9), 1'b0, 1'b0);
    send_cp(CP_W'(21'h00660), 1'b0, 1'b0);
    send_cp(CP_W'(21'h0FF19), 1'b0, 1'b0);
    send_cp(CP_W'(21'h00000), 1'b0, 1'b0);
    send_cp(CP_W'(21'h00030), 1'b0, 1'b0);
    send_cp(CP_W'(21'h10FFFF), 1'b1, 1'b0);
    send_cp(CP_W'(21'h00667), 1'b1, 1'b1);
    send_cp(CP_W'(21'h0002F), 1'b1, 1'b0);
    send_cp(CP_W'(21'h00031), 1'b1, 1'b0);
    send_cp(CP_W'(21'h0003A), 1'b0, 1'b0);
    send_cp(CP_W'(21'h1D7CE), 1'b1, 1'b0);
    send_cp(CP_W'(21'h1D7D8), 1'b0, 1'b0);
    send_cp(CP_W'(21'h1D7E1), 1'b0, 1'b1);
    send_cp(CP_W'(21'h00039), 1'b1, 1'b0);
    send_cp(CP_W'(21'h00038), 1'b1, 1'b0);
    send_cp(CP_W'(21'h0002C), 1'b0, 1'b1);
    send_cp(CP_W'(21'h00036), 1'b0, 1'b1);
  endtask

  task automatic run_flood();
    int k;
    quiet        = 1'b1;
    hold_pending = 1'b1;
    wait (!hold_pending);
    for (k = 0; k < FLOOD_ITEMS; k++) begin
      send_cp(random_digit(), k == 0, k == FLOOD_ITEMS - 1);
    end
    quiet = 1'b0;
  endtask

  task automatic run_random();
    int base;
    int choice;
    int len;
    int k;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) quiet = !quiet;
      if (choice < 85) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          send_cp(random_digit(), k == 0, choice < 40 && k == len - 1);
        end
        if (choice >= 40 && choice < 75) begin
          send_cp(random_separator(), 1'b0, 1'($urandom_range(0, 1)));
        end
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          send_cp(($urandom_range(0, 1) == 0) ? random_digit() : random_separator(),
                  $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.code_point   <= '0;
    req_ch.start_number <= 1'b0;
    req_ch.last_in_line <= 1'b0;
    items_sent     = 0;
    numbers_opened = 0;
    quiet          = 1'b0;
    hold_pending   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    wait_for_results();
    run_flood();
    wait_for_results();
    run_random();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d code points opening %0d numbers, digits drawn from every script zero",
             items_sent, numbers_opened);
    $display("Receiver held off %0d cycles under a full input; results drained between phases",
             LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : result_sink
    int n;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = idle_length();
        if (n > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        rsp_ch.ready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
